>>> rtl/calendar_date_validate_convert_top_defines.svh
// ---------------------------------------------------------------------------
// Calendar date validate/convert: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held low.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_VALIDATE_CONVERT_TOP_DEFINES_SVH
`define CALENDAR_DATE_VALIDATE_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication.
`define CDVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdvc port check failed");

// Next-cycle implication.
`define CDVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdvc port check failed");

`endif

>>> rtl/cdvc_pkg.sv
// ---------------------------------------------------------------------------
// Calendar date validate/convert: shared package
// Status codes, month tables and the decode result struct.
// ---------------------------------------------------------------------------
package cdvc_pkg;

    typedef enum logic [2:0] {
        ST_OK,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_DOY,
        ST_HOUR,
        ST_MINUTE,
        ST_SECOND
    } t_status;

    localparam logic [13:0] YEAR_MIN     = 14'd1900;
    localparam logic [13:0] YEAR_MAX     = 14'd2400;
    localparam logic [18:0] DAY_BIAS     = 19'd36524;
    localparam logic [25:0] MICROS_MIN   = 26'd60000000;
    localparam logic [26:0] SEC_MICROS_MAX = 27'd59999999;
    localparam logic [36:0] MICROS_DAY   = 37'd86400000000;

    // Decode stage result.
    typedef struct packed {
        t_status     status;
        logic [8:0]  doy;
        logic [3:0]  mon;
        logic [4:0]  dom;
        logic [8:0]  y1;        // year - 1900
        logic [6:0]  leapdays;
        logic [10:0] mm;        // minute of day
    } t_dec;

    // Leap-year basis start day, month index 0..11.
    function automatic logic [8:0] f_month_start(input logic [3:0] idx);
        logic [8:0] s;
        unique case (idx)
            4'd0:    s = 9'd1;
            4'd1:    s = 9'd32;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd183;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd336;
            default: s = 9'd1;
        endcase
        return s;
    endfunction

    // Leap-year basis month length, month index 0..11.
    function automatic logic [4:0] f_month_len(input logic [3:0] idx);
        logic [4:0] l;
        unique case (idx)
            4'd1:                      l = 5'd29;
            4'd3, 4'd5, 4'd8, 4'd10:   l = 5'd30;
            default:                   l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

>>> rtl/cdvc_decode.sv
// ---------------------------------------------------------------------------
// Calendar date validate/convert: field decode
// Range checks in priority order, leap rule, day of year, month, day of
// month, leap-day count and minute of day.
// ---------------------------------------------------------------------------
module cdvc_decode import cdvc_pkg::*; (
    input  logic        i_operation,
    input  logic [13:0] i_year,
    input  logic [6:0]  i_month_in,
    input  logic [6:0]  i_day_in,
    input  logic [9:0]  i_ordinal_in,
    input  logic [6:0]  i_hour,
    input  logic [6:0]  i_minute,
    input  logic [26:0] i_second_micros,
    output t_dec        o_dec
);

    logic        year_ok;
    logic        leap;
    logic        mon_ok;
    logic [3:0]  midx;
    logic        day_ok;
    logic        ord_ok;
    logic [8:0]  cal_doy;
    logic [8:0]  ord;
    logic [3:0]  cnt;
    logic [8:0]  ostart;
    logic [8:0]  cstart;
    logic [8:0]  y1;
    logic [8:0]  y1m;
    logic [1:0]  cent;

    assign year_ok = (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX);
    // century years in range that are not leap
    assign leap = (i_year[1:0] == 2'b00) &&
                  !((i_year == 14'd1900) || (i_year == 14'd2100) ||
                    (i_year == 14'd2200) || (i_year == 14'd2300));

    assign mon_ok = (i_month_in >= 7'd1) && (i_month_in <= 7'd12);
    assign midx   = i_month_in[3:0] - 4'd1;
    assign day_ok = (i_day_in >= 7'd1) &&
                    (i_day_in <= {2'b00, f_month_len(midx)}) &&
                    !((midx == 4'd1) && !leap && (i_day_in > 7'd28));

    assign cstart  = f_month_start(midx) - {8'd0, (!leap && (midx > 4'd1))};
    assign cal_doy = {2'b00, i_day_in} + cstart - 9'd1;

    assign ord    = i_ordinal_in[8:0];
    assign ord_ok = (i_ordinal_in >= 10'd1) && (i_ordinal_in <= 10'd366) &&
                    !(!leap && (i_ordinal_in == 10'd366));

    // month = 1 + number of later month starts already reached
    always_comb begin
        cnt = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (ord >= f_month_start(4'(i)) - {8'd0, (!leap && (i > 1))}) begin
                cnt = cnt + 4'd1;
            end
        end
    end
    assign ostart = f_month_start(cnt) - {8'd0, (!leap && (cnt > 4'd1))};

    assign y1  = 9'(i_year - YEAR_MIN);
    assign y1m = y1 - 9'd1;
    always_comb begin
        priority if (i_year > 14'd2300) begin
            cent = 2'd3;
        end else if (i_year > 14'd2200) begin
            cent = 2'd2;
        end else if (i_year > 14'd2100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
    end

    always_comb begin
        priority if (!year_ok) begin
            o_dec.status = ST_YEAR;
        end else if (!i_operation && !mon_ok) begin
            o_dec.status = ST_MONTH;
        end else if (!i_operation && !day_ok) begin
            o_dec.status = ST_DAY;
        end else if (i_operation && !ord_ok) begin
            o_dec.status = ST_DOY;
        end else if (i_hour > 7'd23) begin
            o_dec.status = ST_HOUR;
        end else if (i_minute > 7'd59) begin
            o_dec.status = ST_MINUTE;
        end else if (i_second_micros > SEC_MICROS_MAX) begin
            o_dec.status = ST_SECOND;
        end else begin
            o_dec.status = ST_OK;
        end
    end

    always_comb begin
        if (i_operation) begin
            o_dec.doy = ord;
            o_dec.mon = cnt + 4'd1;
            o_dec.dom = 5'(ord - ostart + 9'd1);
        end else begin
            o_dec.doy = cal_doy;
            o_dec.mon = i_month_in[3:0];
            o_dec.dom = i_day_in[4:0];
        end
    end

    assign o_dec.y1       = y1;
    assign o_dec.leapdays = (y1 == 9'd0) ? 7'd0 : (7'(y1m >> 2) - {5'd0, cent});
    assign o_dec.mm       = ({6'd0, i_hour[4:0]} * 11'd60) + {5'd0, i_minute[5:0]};

endmodule

>>> rtl/calendar_date_validate_convert_top.sv
// ---------------------------------------------------------------------------
// Calendar date validate/convert: top level
// Checks separated date/time fields and converts them to ordinal form,
// a day count relative to 2000 and microseconds of day.
// ---------------------------------------------------------------------------
// One result beat per input beat, one beat per cycle sustained while
// the output is not stalled. An accepted beat passes in order through
// three register stages on its way to o_valid: decode and range
// checks, then the day count multiply plus the minute-of-day by 60e6
// multiply, then the final microsecond add and error zeroing into the
// output register. Any failed check reports its
// status code with all other result fields zero; checks run year, month,
// day of month, day of year, hour, minute, second, and the first failure
// wins. Day 1 of the day count is January 1, 2000. The block keeps no state
// between beats. Stall propagates back through stages that hold data, so
// bubbles are squeezed out and nothing is dropped.
// ---------------------------------------------------------------------------
module calendar_date_validate_convert_top import cdvc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [13:0]        i_year,
    input  logic [6:0]         i_month_in,
    input  logic [6:0]         i_day_in,
    input  logic [9:0]         i_ordinal_in,
    input  logic [6:0]         i_hour,
    input  logic [6:0]         i_minute,
    input  logic [26:0]        i_second_micros,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [8:0]         o_day_of_year,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_of_month,
    output logic signed [18:0] o_days_since_2000,
    output logic [36:0]        o_micros_of_day
);

    // stage advance enables, back to front
    logic adv1, adv2, adv3;

    // stage 1: decoded fields
    t_dec        n_d1;
    t_dec        r_d1;
    logic [26:0] r_sec1;
    logic        r_v1;

    // stage 2: day count and time product
    t_status     r_st2;
    logic [8:0]  r_doy2;
    logic [3:0]  r_mon2;
    logic [4:0]  r_dom2;
    logic [18:0] r_jd2;
    logic [36:0] r_prod2;
    logic [26:0] r_sec2;
    logic        r_v2;
    logic [18:0] n_jd2;
    logic [36:0] n_prod2;

    // stage 3: output register
    t_status     r_st3;
    logic [8:0]  r_doy3;
    logic [3:0]  r_mon3;
    logic [4:0]  r_dom3;
    logic [18:0] r_jd3;
    logic [36:0] r_us3;
    logic        r_v3;
    logic        ok2;

    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    cdvc_decode u_decode (
        .i_operation     (i_operation),
        .i_year          (i_year),
        .i_month_in      (i_month_in),
        .i_day_in        (i_day_in),
        .i_ordinal_in    (i_ordinal_in),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second_micros (i_second_micros),
        .o_dec           (n_d1)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_d1   <= n_d1;
            r_sec1 <= i_second_micros;
        end
    end

    // days = y1*365 + leap days + doy - 36524, wraps into 19-bit signed
    assign n_jd2   = 19'({10'd0, r_d1.y1} * 19'd365) + {12'd0, r_d1.leapdays} +
                     {10'd0, r_d1.doy} - DAY_BIAS;
    assign n_prod2 = {26'd0, r_d1.mm} * {11'd0, MICROS_MIN};

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_st2   <= r_d1.status;
            r_doy2  <= r_d1.doy;
            r_mon2  <= r_d1.mon;
            r_dom2  <= r_d1.dom;
            r_jd2   <= n_jd2;
            r_prod2 <= n_prod2;
            r_sec2  <= r_sec1;
        end
    end

    // final add; error beats carry zeros
    assign ok2 = (r_st2 == ST_OK);

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_st3  <= r_st2;
            r_doy3 <= ok2 ? r_doy2 : 9'd0;
            r_mon3 <= ok2 ? r_mon2 : 4'd0;
            r_dom3 <= ok2 ? r_dom2 : 5'd0;
            r_jd3  <= ok2 ? r_jd2  : 19'd0;
            r_us3  <= ok2 ? (r_prod2 + {10'd0, r_sec2}) : 37'd0;
        end
    end

    assign o_valid           = r_v3;
    assign o_status          = r_st3;
    assign o_day_of_year     = r_doy3;
    assign o_month_out       = r_mon3;
    assign o_day_of_month    = r_dom3;
    assign o_days_since_2000 = signed'(r_jd3);
    assign o_micros_of_day   = r_us3;

endmodule

>>> rtl/cdvc_checker.sv
// ---------------------------------------------------------------------------
// Calendar date validate/convert: port checker
// Watches the top level ports for result consistency and latency.
// ---------------------------------------------------------------------------
`include "calendar_date_validate_convert_top_defines.svh"

module cdvc_checker import cdvc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [2:0]         o_status,
    input  logic [8:0]         o_day_of_year,
    input  logic [3:0]         o_month_out,
    input  logic [4:0]         o_day_of_month,
    input  logic signed [18:0] o_days_since_2000,
    input  logic [36:0]        o_micros_of_day
);

    // held beat stays put
    `CDVC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_days_since_2000) && $stable(o_micros_of_day))

    // failed checks carry zero fields
    `CDVC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_day_of_year == 9'd0) && (o_month_out == 4'd0) && (o_day_of_month == 5'd0) && (o_days_since_2000 == 19'sd0) && (o_micros_of_day == 37'd0))

    // good beats stay in calendar range
    `CDVC_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, o_valid && (o_status == ST_OK), (o_day_of_year != 9'd0) && (o_month_out != 4'd0) && (o_month_out <= 4'd12) && (o_day_of_month != 5'd0) && (o_micros_of_day < MICROS_DAY))

    // an accepted beat reaches o_valid when the output does not stall in between
    `CDVC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall, o_valid)

endmodule

bind calendar_date_validate_convert_top cdvc_checker u_cdvc_checker (.*);

>>> verif/calendar_date_validate_convert_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Calendar date validate/convert: block-level test
// Drives date/time beats in calendar and ordinal mode through the input
// channel and checks every result beat, field by field, against a local
// predictor. Both channels idle and stall at random, with burst phases in
// which neither side idles.
// ---------------------------------------------------------------------------
module calendar_date_validate_convert_top_test;
    import cdvc_pkg::*;

    // Operation codes of the input beat.
    localparam bit OP_CALENDAR = 1'b0;
    localparam bit OP_ORDINAL  = 1'b1;

    // Overall run limit, far above the slowest legal run.
    localparam int RUN_LIMIT_NS = 2_000_000;

    // One input beat.
    typedef struct {
        bit          op;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [9:0]  ordinal;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [26:0] sec_us;
    } t_stamp;

    // One result beat.
    typedef struct {
        t_status            status;
        logic [8:0]         doy;
        logic [3:0]         month;
        logic [4:0]         dom;
        logic signed [18:0] days;
        logic [36:0]        micros;
    } t_ordinal_date;

    // Leap-year basis calendar: first day of each month and month length.
    int unsigned first_day[12]  = '{1, 32, 61, 92, 122, 153, 183, 214, 245, 275, 306, 336};
    int unsigned month_days[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    // Years that sit on a leap-rule or range boundary.
    int unsigned edge_years[6]  = '{1900, 1901, 2000, 2100, 2101, 2400};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_operation;
    logic [13:0]        i_year;
    logic [6:0]         i_month_in;
    logic [6:0]         i_day_in;
    logic [9:0]         i_ordinal_in;
    logic [6:0]         i_hour;
    logic [6:0]         i_minute;
    logic [26:0]        i_second_micros;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [8:0]         o_day_of_year;
    logic [3:0]         o_month_out;
    logic [4:0]         o_day_of_month;
    logic signed [18:0] o_days_since_2000;
    logic [36:0]        o_micros_of_day;

    t_ordinal_date pending_dates[$];   // expected results, oldest first
    bit            burst = 1'b0;       // no idling on either side while set
    int            sink_wait = 0;      // stall cycles left before the next result
    int            n_sent = 0;
    int            n_checked = 0;
    int            n_fail = 0;
    int            status_seen[8];

    calendar_date_validate_convert_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_year            (i_year),
        .i_month_in        (i_month_in),
        .i_day_in          (i_day_in),
        .i_ordinal_in      (i_ordinal_in),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second_micros   (i_second_micros),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_day_of_year     (o_day_of_year),
        .o_month_out       (o_month_out),
        .o_day_of_month    (o_day_of_month),
        .o_days_since_2000 (o_days_since_2000),
        .o_micros_of_day   (o_micros_of_day)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still pending", $time, pending_dates.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: validation order is year, then month/day or day of year
    // (leap rule included), then hour, minute, second. First failure wins
    // and zeroes every other field.
    // ------------------------------------------------------------------
    function automatic t_ordinal_date to_ordinal_date(input t_stamp s);
        t_ordinal_date r;
        t_status       st;
        bit            leap;
        int unsigned   y, m_in, d_in, ord, doy, mon, dom, y1, leapdays, start;
        int            days;

        y    = 32'(s.year);
        m_in = 32'(s.month);
        d_in = 32'(s.day);
        ord  = 32'(s.ordinal);
        st   = ST_OK;
        doy  = 0;
        mon  = 0;
        dom  = 0;
        days = 0;
        if (y < 1900 || y > 2400) begin
            st = ST_YEAR;
        end else begin
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            if (s.op == OP_CALENDAR) begin
                if (m_in < 1 || m_in > 12) begin
                    st = ST_MONTH;
                end else if (d_in < 1 || d_in > month_days[m_in - 1] ||
                             (m_in == 2 && !leap && d_in > 28)) begin
                    st = ST_DAY;
                end else begin
                    mon = m_in;
                    dom = d_in;
                    doy = dom + first_day[mon - 1] - 1;
                    if (!leap && mon > 2)
                        doy--;
                end
            end else begin
                if (ord < 1 || ord > 366 || (!leap && ord == 366)) begin
                    st = ST_DOY;
                end else begin
                    doy = ord;
                    // month starts are ascending: last start reached is the month
                    mon = 1;
                    for (int i = 1; i < 12; i++) begin
                        start = first_day[i] - ((!leap && i > 1) ? 1 : 0);
                        if (doy >= start)
                            mon = i + 1;
                    end
                    start = first_day[mon - 1] - ((!leap && mon > 2) ? 1 : 0);
                    dom = doy - start + 1;
                end
            end
            if (st == ST_OK) begin
                // leap days since 1900; century correction only past 2100
                y1 = y - 1900;
                leapdays = (y1 > 0) ? (y1 - 1) / 4 : 0;
                if (y > 2100)
                    leapdays -= (y - 2001) / 100;
                days = int'(y1 * 365 + leapdays + doy) - 36524;
                if (s.hour > 23)
                    st = ST_HOUR;
                else if (s.minute > 59)
                    st = ST_MINUTE;
                else if (s.sec_us > 59999999)
                    st = ST_SECOND;
            end
        end
        r.status = st;
        if (st == ST_OK) begin
            r.doy    = 9'(doy);
            r.month  = 4'(mon);
            r.dom    = 5'(dom);
            r.days   = 19'(days);
            r.micros = 37'(((longint'(s.hour) * 60 + s.minute) * 60) * 1000000 + s.sec_us);
        end else begin
            r.doy    = '0;
            r.month  = '0;
            r.dom    = '0;
            r.days   = '0;
            r.micros = '0;
        end
        return r;
    endfunction

    function automatic t_stamp make_stamp(input bit op, input int unsigned year,
                                          input int unsigned month, input int unsigned day,
                                          input int unsigned ordinal, input int unsigned hour,
                                          input int unsigned minute,
                                          input int unsigned sec_us);
        t_stamp s;
        s.op      = op;
        s.year    = 14'(year);
        s.month   = 7'(month);
        s.day     = 7'(day);
        s.ordinal = 10'(ordinal);
        s.hour    = 7'(hour);
        s.minute  = 7'(minute);
        s.sec_us  = 27'(sec_us);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Sender: called and returns at a falling edge. Valid stays high
    // across back-to-back beats; the payload holds while stalled.
    // ------------------------------------------------------------------
    task automatic send_stamp(input t_stamp s);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation     <= s.op;
        i_year          <= s.year;
        i_month_in      <= s.month;
        i_day_in        <= s.day;
        i_ordinal_in    <= s.ordinal;
        i_hour          <= s.hour;
        i_minute        <= s.minute;
        i_second_micros <= s.sec_us;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_dates.push_back(to_ordinal_date(s));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result is back, then let the
    // three-stage pipeline settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall is drawn per result beat and driven at falling edges.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            i_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input longint expv, input longint actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            n_fail++;
        end
    endtask

    // Result checker: every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_ordinal_date e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result beat with nothing pending, status %0d", $time, o_status);
                n_fail++;
            end else begin
                e = pending_dates.pop_front();
                check_field("status", longint'(e.status), longint'(o_status));
                check_field("day_of_year", longint'(e.doy), longint'(o_day_of_year));
                check_field("month_out", longint'(e.month), longint'(o_month_out));
                check_field("day_of_month", longint'(e.dom), longint'(o_day_of_month));
                check_field("days_since_2000", longint'(e.days),
                            longint'(o_days_since_2000));
                check_field("micros_of_day", longint'(e.micros), longint'(o_micros_of_day));
                status_seen[o_status]++;
                n_checked++;
            end
            sink_wait = burst ? 0 : $urandom_range(0, 6);
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Year range edges; a bad year wins over every later check.
    task automatic test_year_limits();
        send_stamp(make_stamp(OP_CALENDAR, 1899, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 1900, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2400, 12, 31, 0, 23, 59, 59999999));
        send_stamp(make_stamp(OP_CALENDAR, 2401, 1, 1, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 0, 0, 0, 1, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 9999, 99, 99, 999, 99, 99, 99999999));
    endtask

    // Calendar mode: leap rule, month lengths, month/day range.
    task automatic test_calendar_dates();
        send_stamp(make_stamp(OP_CALENDAR, 2000, 1, 1, 999, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2000, 2, 29, 0, 12, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 1900, 2, 29, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2100, 2, 29, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2400, 2, 29, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2004, 4, 31, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2023, 12, 31, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2010, 0, 5, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2010, 13, 5, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2010, 5, 0, 0, 0, 0, 0));
    endtask

    // Ordinal mode: day-of-year range, day 366, month derivation around
    // February; month and day fields are junk and must be ignored.
    task automatic test_ordinal_dates();
        send_stamp(make_stamp(OP_ORDINAL, 2000, 99, 99, 0, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 2000, 0, 0, 366, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 1999, 0, 0, 366, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 2000, 13, 0, 60, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 2001, 0, 40, 60, 0, 0, 0));
        send_stamp(make_stamp(OP_ORDINAL, 2000, 1, 1, 367, 0, 0, 0));
    endtask

    // Time of day: each field just past its limit, and all at once.
    task automatic test_time_limits();
        burst = 1'b1;
        send_stamp(make_stamp(OP_CALENDAR, 2020, 6, 15, 0, 24, 0, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2020, 6, 15, 0, 0, 60, 0));
        send_stamp(make_stamp(OP_CALENDAR, 2020, 6, 15, 0, 0, 0, 60000000));
        send_stamp(make_stamp(OP_ORDINAL, 2020, 0, 0, 100, 99, 99, 99999999));
        burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random beats: mostly well-formed dates with random content, some with
    // one field broken, the rest noise over the full field ranges. Burst
    // phases switch on at random every 150 beats.
    // ------------------------------------------------------------------
    task automatic test_random_stamps(input int count);
        t_stamp s;
        int     kind;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                if (n > 0 && $urandom_range(0, 2) == 0)
                    wait_idle();
                burst = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                s.op      = 1'($urandom_range(0, 1));
                s.year    = 14'(($urandom_range(0, 3) == 0) ? edge_years[$urandom_range(0, 5)]
                                                            : $urandom_range(1900, 2400));
                s.month   = 7'($urandom_range(1, 12));
                s.day     = 7'($urandom_range(1, month_days[s.month - 1]));
                s.ordinal = 10'($urandom_range(1, 366));
                s.hour    = 7'($urandom_range(0, 23));
                s.minute  = 7'($urandom_range(0, 59));
                s.sec_us  = 27'($urandom_range(0, 59999999));
                if (kind >= 6) begin
                    case ($urandom_range(0, 6))
                        0: s.year    = 14'($urandom_range(0, 1) ? $urandom_range(0, 1899)
                                                                : $urandom_range(2401, 9999));
                        1: s.month   = 7'($urandom_range(0, 1) ? 0 : $urandom_range(13, 99));
                        2: s.day     = 7'($urandom_range(0, 1) ? 0 : $urandom_range(29, 99));
                        3: s.ordinal = 10'($urandom_range(0, 1) ? 0
                                                                : $urandom_range(365, 999));
                        4: s.hour    = 7'($urandom_range(24, 99));
                        5: s.minute  = 7'($urandom_range(60, 99));
                        default: s.sec_us = 27'($urandom_range(60000000, 99999999));
                    endcase
                end
            end else begin
                s.op      = 1'($urandom_range(0, 1));
                s.year    = 14'($urandom_range(0, 9999));
                s.month   = 7'($urandom_range(0, 99));
                s.day     = 7'($urandom_range(0, 99));
                s.ordinal = 10'($urandom_range(0, 999));
                s.hour    = 7'($urandom_range(0, 99));
                s.minute  = 7'($urandom_range(0, 99));
                s.sec_us  = 27'($urandom_range(0, 99999999));
            end
            send_stamp(s);
        end
        burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_CALENDAR;
        i_year          = '0;
        i_month_in      = '0;
        i_day_in        = '0;
        i_ordinal_in    = '0;
        i_hour          = '0;
        i_minute        = '0;
        i_second_micros = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_year_limits();
        test_calendar_dates();
        test_ordinal_dates();
        test_time_limits();
        // sender pause: everything in flight has to drain first
        wait_idle();
        test_random_stamps(1650);
        wait_idle();

        $display("sent %0d date beats (directed edges, leap rule, time limits, random mix)",
                 n_sent);
        $display("checked %0d results: ok %0d year %0d month %0d day %0d doy %0d",
                 n_checked, status_seen[ST_OK], status_seen[ST_YEAR], status_seen[ST_MONTH],
                 status_seen[ST_DAY], status_seen[ST_DOY]);
        $display("    hour %0d min %0d sec %0d",
                 status_seen[ST_HOUR], status_seen[ST_MINUTE], status_seen[ST_SECOND]);
        if (n_fail == 0 && pending_dates.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
